@@ design/saf_pkg.sv @@
`default_nettype none
package saf_pkg;

  localparam int PosW     = 24;
  localparam int QuatW    = 16;
  localparam int SizeW    = 16;
  localparam int CoefW    = 16;
  localparam int CfgW     = 64;
  localparam int CfgIdxW  = 3;
  localparam int MagW     = 30;
  localparam int RootW    = 32;
  localparam int NormW    = 64;
  localparam int QuoW     = 15;
  localparam int RemW     = 48;
  localparam int SqrtSteps = 32;
  localparam int DivSteps  = QuoW;

  // Register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CfgRowX, CfgRowY, CfgRowZ, CfgOffX, CfgOffY, CfgOffZ, CfgQuat, CfgScm
  } cfg_idx_e;

  localparam int ModeRotBit   = 48;
  localparam int ModeScaleBit = 49;

  localparam logic [47:0] RowXReset = 48'd4096;
  localparam logic [47:0] RowYReset = 48'd4096 << 16;
  localparam logic [47:0] RowZReset = 48'd4096 << 32;
  localparam logic [63:0] QuatReset = 64'd16384 << 48;
  localparam logic [49:0] ScmReset  = (50'd3 << 48) | (50'd4096 << 32) |
                                      (50'd4096 << 16) | 50'd4096;
  localparam logic [QuatW-1:0] QuatOne = 16'd16384;

  typedef struct packed {
    logic [2:0][47:0]     row;
    logic [2:0][PosW-1:0] off;
    logic [63:0]          quat;
    logic [49:0]          scm;
  } cfg_t;

  // Fields that ride along with the normalization pipeline
  typedef struct packed {
    logic [2:0][PosW-1:0]  pos;
    logic [2:0][SizeW-1:0] size;
    logic [3:0][QuatW-1:0] qin;
    logic [3:0]            neg;
    logic                  zero;
    logic [3:0][MagW-1:0]  mag;
  } side_t;

  typedef struct packed {
    logic [2:0][PosW-1:0]  pos;
    logic [3:0][QuatW-1:0] quat;
    logic [2:0][SizeW-1:0] size;
  } res_t;

endpackage
`default_nettype wire

@@ design/saf_if.sv @@
`default_nettype none
interface saf_in_if;
  logic              valid;
  logic              ready;
  logic signed [23:0] pos_x;
  logic signed [23:0] pos_y;
  logic signed [23:0] pos_z;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;
  logic [15:0]        size_x;
  logic [15:0]        size_y;
  logic [15:0]        size_z;
  modport source (output valid, pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w,
                  size_x, size_y, size_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w,
                size_x, size_y, size_z, output ready);
endinterface

interface saf_out_if;
  logic              valid;
  logic              ready;
  logic signed [23:0] new_pos_x;
  logic signed [23:0] new_pos_y;
  logic signed [23:0] new_pos_z;
  logic signed [15:0] new_quat_x;
  logic signed [15:0] new_quat_y;
  logic signed [15:0] new_quat_z;
  logic signed [15:0] new_quat_w;
  logic [15:0]        new_size_x;
  logic [15:0]        new_size_y;
  logic [15:0]        new_size_z;
  modport source (output valid, new_pos_x, new_pos_y, new_pos_z, new_quat_x, new_quat_y,
                  new_quat_z, new_quat_w, new_size_x, new_size_y, new_size_z, input ready);
  modport sink (input valid, new_pos_x, new_pos_y, new_pos_z, new_quat_x, new_quat_y,
                new_quat_z, new_quat_w, new_size_x, new_size_y, new_size_z, output ready);
endinterface
`default_nettype wire

@@ design/saf_front.sv @@
`default_nettype none
module saf_front (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            en_i,
  input  wire logic                            valid_i,
  input  wire logic [2:0][saf_pkg::PosW-1:0]   pos_i,
  input  wire logic [3:0][saf_pkg::QuatW-1:0]  quat_i,
  input  wire logic [2:0][saf_pkg::SizeW-1:0]  size_i,
  input  wire saf_pkg::cfg_t                   cfg_i,
  output logic                                 valid_o,
  output saf_pkg::side_t                       side_o,
  output logic [saf_pkg::NormW-1:0]            norm_o
);
  import saf_pkg::*;

  logic [4:0] vld_q;

  // Stage 1: products
  logic signed [39:0]     pp_q [3][3];
  logic signed [31:0]     m_q  [4][4];
  logic [31:0]            sp_q [3];
  logic [3:0][QuatW-1:0]  qin1_q;
  logic [2:0][SizeW-1:0]  size1_q;

  // Stage 2: sums
  logic signed [30:0]     pos2_q [3];
  logic signed [33:0]     prod2_q [4];
  logic [2:0][SizeW-1:0]  size2_q;
  logic [3:0][QuatW-1:0]  qin2_q;

  // Stage 3..5
  side_t                  side3_q, side4_q, side5_q;
  logic [59:0]            sq4_q [4];
  logic [NormW-1:0]       norm5_q;

  logic signed [42:0]     acc [3];
  logic signed [42:0]     rnd [3];
  logic signed [33:0]     prod [4];
  logic [32:0]            sr [3];
  logic [2:0][SizeW-1:0]  size2_d;
  logic [32:0]            mag33 [4];
  logic [1:0]             shamt;
  logic [2:0][PosW-1:0]   pos3_d;
  side_t                  side3_d;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  // Stage 2 logic: position sums with rounding, quaternion product, scales
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = {{7{cfg_i.off[i][PosW-1]}}, cfg_i.off[i], 12'b0}
             + 43'(pp_q[i][0]) + 43'(pp_q[i][1]) + 43'(pp_q[i][2]);
      rnd[i] = acc[i] + 43'sd2048;
      sr[i]  = 33'(sp_q[i]) + 33'd2048;
      if (!cfg_i.scm[ModeScaleBit]) begin
        size2_d[i] = size1_q[i];
      end else if (sr[i][32:12] > 21'd65535) begin
        size2_d[i] = '1;
      end else begin
        size2_d[i] = sr[i][27:12];
      end
    end
    prod[3] = 34'(m_q[3][3]) - 34'(m_q[0][0]) - 34'(m_q[1][1]) - 34'(m_q[2][2]);
    prod[0] = 34'(m_q[3][0]) + 34'(m_q[0][3]) + 34'(m_q[1][2]) - 34'(m_q[2][1]);
    prod[1] = 34'(m_q[3][1]) - 34'(m_q[0][2]) + 34'(m_q[1][3]) + 34'(m_q[2][0]);
    prod[2] = 34'(m_q[3][2]) + 34'(m_q[0][1]) - 34'(m_q[1][0]) + 34'(m_q[2][3]);
  end

  // Stage 3 logic: saturate position, take magnitudes and bring them under 2^30
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (pos2_q[i] > 31'sd8388607) begin
        pos3_d[i] = 24'h7FFFFF;
      end else if (pos2_q[i] < -31'sd8388608) begin
        pos3_d[i] = 24'h800000;
      end else begin
        pos3_d[i] = pos2_q[i][PosW-1:0];
      end
    end
    for (int i = 0; i < 4; i++) begin
      mag33[i] = prod2_q[i][33] ? 33'(-prod2_q[i]) : prod2_q[i][32:0];
    end
    priority if ((mag33[0][32] | mag33[1][32] | mag33[2][32] | mag33[3][32]) == 1'b1) begin
      shamt = 2'd3;
    end else if ((mag33[0][31] | mag33[1][31] | mag33[2][31] | mag33[3][31]) == 1'b1) begin
      shamt = 2'd2;
    end else if ((mag33[0][30] | mag33[1][30] | mag33[2][30] | mag33[3][30]) == 1'b1) begin
      shamt = 2'd1;
    end else begin
      shamt = 2'd0;
    end
    side3_d.pos  = pos3_d;
    side3_d.size = size2_q;
    side3_d.qin  = qin2_q;
    side3_d.zero = (mag33[0] == '0) && (mag33[1] == '0) && (mag33[2] == '0) &&
                   (mag33[3] == '0);
    for (int i = 0; i < 4; i++) begin
      side3_d.neg[i] = prod2_q[i][33];
      side3_d.mag[i] = MagW'(mag33[i] >> shamt);
    end
  end

  // Hold payload on stall
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pp_q[i][j] <= $signed(cfg_i.row[i][CoefW*j +: CoefW]) * $signed(pos_i[j]);
        end
        sp_q[i] <= size_i[i] * cfg_i.scm[SizeW*i +: SizeW];
      end
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          m_q[i][j] <= $signed(cfg_i.quat[QuatW*i +: QuatW]) * $signed(quat_i[j]);
        end
      end
      qin1_q  <= quat_i;
      size1_q <= size_i;

      for (int i = 0; i < 3; i++) begin
        pos2_q[i] <= rnd[i][42:12];
      end
      for (int i = 0; i < 4; i++) begin
        prod2_q[i] <= prod[i];
      end
      size2_q <= size2_d;
      qin2_q  <= qin1_q;

      side3_q <= side3_d;

      for (int i = 0; i < 4; i++) begin
        sq4_q[i] <= side3_q.mag[i] * side3_q.mag[i];
      end
      side4_q <= side3_q;

      norm5_q <= NormW'(sq4_q[0]) + NormW'(sq4_q[1]) + NormW'(sq4_q[2]) + NormW'(sq4_q[3]);
      side5_q <= side4_q;
    end
  end

  assign valid_o = vld_q[4];
  assign side_o  = side5_q;
  assign norm_o  = norm5_q;

endmodule
`default_nettype wire

@@ design/saf_sqrt.sv @@
`default_nettype none
module saf_sqrt (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         valid_i,
  input  wire saf_pkg::side_t               side_i,
  input  wire logic [saf_pkg::NormW-1:0]    norm_i,
  output logic                              valid_o,
  output saf_pkg::side_t                    side_o,
  output logic [saf_pkg::RootW-1:0]         root_o
);
  import saf_pkg::*;

  logic [SqrtSteps-1:0] vld_q;
  logic [NormW-1:0]     n_q    [SqrtSteps];
  logic [NormW-1:0]     r_q    [SqrtSteps];
  side_t                side_q [SqrtSteps];

  // One result bit per stage
  for (genvar s = 0; s < SqrtSteps; s++) begin : g_step
    localparam logic [NormW-1:0] Bit = NormW'(1) << (2 * (SqrtSteps - 1 - s));
    logic [NormW-1:0] n_in, r_in, trial, n_d, r_d;
    logic             v_in;
    side_t            s_in;

    if (s == 0) begin : g_first
      assign n_in = norm_i;
      assign r_in = '0;
      assign v_in = valid_i;
      assign s_in = side_i;
    end else begin : g_next
      assign n_in = n_q[s-1];
      assign r_in = r_q[s-1];
      assign v_in = vld_q[s-1];
      assign s_in = side_q[s-1];
    end

    always_comb begin
      trial = r_in + Bit;
      if (n_in >= trial) begin
        n_d = n_in - trial;
        r_d = (r_in >> 1) + Bit;
      end else begin
        n_d = n_in;
        r_d = r_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[s]    <= n_d;
        r_q[s]    <= r_d;
        side_q[s] <= s_in;
      end
    end
  end

  assign valid_o = vld_q[SqrtSteps-1];
  assign side_o  = side_q[SqrtSteps-1];
  assign root_o  = r_q[SqrtSteps-1][RootW-1:0];

endmodule
`default_nettype wire

@@ design/saf_div.sv @@
`default_nettype none
module saf_div (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           en_i,
  input  wire logic                           valid_i,
  input  wire saf_pkg::side_t                 side_i,
  input  wire logic [saf_pkg::RootW-1:0]      root_i,
  output logic                                valid_o,
  output saf_pkg::side_t                      side_o,
  output logic [3:0][saf_pkg::QuoW-1:0]       quo_o
);
  import saf_pkg::*;

  logic                  pvld_q;
  side_t                 pside_q;
  logic [RootW:0]        pden_q;
  logic [3:0][RemW-1:0]  prem_q;

  logic [DivSteps-1:0]   vld_q;
  side_t                 side_q [DivSteps];
  logic [RootW:0]        den_q  [DivSteps];
  logic [3:0][RemW-1:0]  rem_q  [DivSteps];
  logic [3:0][QuoW-1:0]  quo_q  [DivSteps];

  // Prepare dividends: 2*mag*16384 + len over 2*len
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvld_q <= 1'b0;
    end else if (en_i) begin
      pvld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pside_q <= side_i;
      pden_q  <= {root_i, 1'b0};
      for (int i = 0; i < 4; i++) begin
        prem_q[i] <= (RemW'(side_i.mag[i]) << 15) + RemW'(root_i);
      end
    end
  end

  // Restoring division, one quotient bit per stage, four lanes
  for (genvar s = 0; s < DivSteps; s++) begin : g_step
    localparam int Shift = DivSteps - 1 - s;
    logic [RootW:0]        den_in;
    logic [3:0][RemW-1:0]  rem_in, rem_d;
    logic [3:0][QuoW-1:0]  quo_in, quo_d;
    logic [RemW-1:0]       trial;
    logic                  v_in;
    side_t                 s_in;

    if (s == 0) begin : g_first
      assign den_in = pden_q;
      assign rem_in = prem_q;
      assign quo_in = '0;
      assign v_in   = pvld_q;
      assign s_in   = pside_q;
    end else begin : g_next
      assign den_in = den_q[s-1];
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
      assign v_in   = vld_q[s-1];
      assign s_in   = side_q[s-1];
    end

    always_comb begin
      trial = RemW'(den_in) << Shift;
      for (int i = 0; i < 4; i++) begin
        if (rem_in[i] >= trial) begin
          rem_d[i] = rem_in[i] - trial;
          quo_d[i] = quo_in[i] | (QuoW'(1) << Shift);
        end else begin
          rem_d[i] = rem_in[i];
          quo_d[i] = quo_in[i];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[s]  <= den_in;
        rem_q[s]  <= rem_d;
        quo_q[s]  <= quo_d;
        side_q[s] <= s_in;
      end
    end
  end

  assign valid_o = vld_q[DivSteps-1];
  assign side_o  = side_q[DivSteps-1];
  assign quo_o   = quo_q[DivSteps-1];

endmodule
`default_nettype wire

@@ design/splat_affine_transform.sv @@
// Gaussian splat affine transform.
// Input channel in_i carries one splat per transaction (centre, rotation
// quaternion, axis scales); output channel out_o carries the transformed
// splat. Both use valid/ready; a transaction completes when both are high.
// The configuration port writes one register per cycle with cfg_we_i; the user
// must write it only while no splat is in flight; the block does not check it.
// Throughput: one splat per cycle while the output buffer has room. A splat
// passes 5 stages of products and sums, 32 stages of the integer square root
// of the quaternion norm (one root bit per stage), the normalizing divide (an
// input register, then one quotient bit per stage) and the output buffer.
// Reset clears all valid bits and loads the identity transform with both
// rotation and scale enabled.
// When the receiver stalls, results collect in a two-entry output buffer;
// once it is full the whole pipeline holds and in_i.ready drops, so no
// transaction is lost or repeated.
`default_nettype none
module splat_affine_transform (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  saf_in_if.sink                                 in_i,
  saf_out_if.source                              out_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [saf_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire logic [saf_pkg::CfgW-1:0]          cfg_data_i
);
  import saf_pkg::*;

  cfg_t                  cfg_q;
  logic                  en;
  logic                  front_vld, sqrt_vld, div_vld;
  side_t                 front_side, sqrt_side, div_side;
  logic [NormW-1:0]      norm;
  logic [RootW-1:0]      root;
  logic [3:0][QuoW-1:0]  quo;
  res_t                  res;
  res_t                  fifo_q [2];
  logic                  wr_ptr_q, rd_ptr_q;
  logic [1:0]            cnt_q;
  logic                  push, pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row  <= {RowZReset, RowYReset, RowXReset};
      cfg_q.off  <= '0;
      cfg_q.quat <= QuatReset;
      cfg_q.scm  <= ScmReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgRowX: cfg_q.row[0] <= cfg_data_i[47:0];
        CfgRowY: cfg_q.row[1] <= cfg_data_i[47:0];
        CfgRowZ: cfg_q.row[2] <= cfg_data_i[47:0];
        CfgOffX: cfg_q.off[0] <= cfg_data_i[PosW-1:0];
        CfgOffY: cfg_q.off[1] <= cfg_data_i[PosW-1:0];
        CfgOffZ: cfg_q.off[2] <= cfg_data_i[PosW-1:0];
        CfgQuat: cfg_q.quat   <= cfg_data_i;
        CfgScm:  cfg_q.scm    <= cfg_data_i[49:0];
        default: ;
      endcase
    end
  end

  // Advance the pipeline while the output buffer has room
  assign en         = (cnt_q != 2'd2);
  assign in_i.ready = en;

  saf_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .pos_i   ({in_i.pos_z, in_i.pos_y, in_i.pos_x}),
    .quat_i  ({in_i.quat_w, in_i.quat_z, in_i.quat_y, in_i.quat_x}),
    .size_i  ({in_i.size_z, in_i.size_y, in_i.size_x}),
    .cfg_i   (cfg_q),
    .valid_o (front_vld),
    .side_o  (front_side),
    .norm_o  (norm)
  );

  saf_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (front_vld),
    .side_i  (front_side),
    .norm_i  (norm),
    .valid_o (sqrt_vld),
    .side_o  (sqrt_side),
    .root_o  (root)
  );

  saf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sqrt_vld),
    .side_i  (sqrt_side),
    .root_i  (root),
    .valid_o (div_vld),
    .side_o  (div_side),
    .quo_o   (quo)
  );

  // Assemble the result: pick normalized, identity or passed-through quaternion
  always_comb begin
    res.pos  = div_side.pos;
    res.size = div_side.size;
    for (int i = 0; i < 4; i++) begin
      if (!cfg_q.scm[ModeRotBit]) begin
        res.quat[i] = div_side.qin[i];
      end else if (div_side.zero) begin
        res.quat[i] = (i == 3) ? QuatOne : '0;
      end else if (div_side.neg[i]) begin
        res.quat[i] = QuatW'(-{1'b0, quo[i]});
      end else begin
        res.quat[i] = {1'b0, quo[i]};
      end
    end
  end

  // Two-entry output buffer
  assign push = en && div_vld;
  assign pop  = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= res;
    end
  end

  assign out_o.valid      = (cnt_q != 2'd0);
  assign out_o.new_pos_x  = fifo_q[rd_ptr_q].pos[0];
  assign out_o.new_pos_y  = fifo_q[rd_ptr_q].pos[1];
  assign out_o.new_pos_z  = fifo_q[rd_ptr_q].pos[2];
  assign out_o.new_quat_x = fifo_q[rd_ptr_q].quat[0];
  assign out_o.new_quat_y = fifo_q[rd_ptr_q].quat[1];
  assign out_o.new_quat_z = fifo_q[rd_ptr_q].quat[2];
  assign out_o.new_quat_w = fifo_q[rd_ptr_q].quat[3];
  assign out_o.new_size_x = fifo_q[rd_ptr_q].size[0];
  assign out_o.new_size_y = fifo_q[rd_ptr_q].size[1];
  assign out_o.new_size_z = fifo_q[rd_ptr_q].size[2];

endmodule
`default_nettype wire
